>>> design/gaas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaas_pkg: shared constants and helpers
// Sizes, field widths and 16-bit saturation for the affine alignment block.
// ----------------------------------------------------------------------------
package gaas_pkg;

  localparam int MaxQuery     = 1024;
  localparam int AlphabetSize = 24;
  localparam int QAW          = $clog2(MaxQuery);
  localparam int LenW         = QAW + 1;
  localparam int TabDepth     = AlphabetSize * AlphabetSize;
  localparam int TAW          = $clog2(TabDepth);

  // command codes on command_i
  localparam logic [1:0] CmdTable = 2'd0;
  localparam logic [1:0] CmdQuery = 2'd1;
  localparam logic [1:0] CmdDb    = 2'd2;
  localparam logic [1:0] CmdNone  = 2'd3;

  // register indexes on the APB port
  localparam logic [1:0] RegOpen  = 2'd0;
  localparam logic [1:0] RegExt   = 2'd1;
  localparam logic [1:0] RegLen   = 2'd2;

  typedef logic signed [15:0] score_t;
  typedef logic signed [25:0] wide_t;

  // clamp to the 16-bit signed range
  function automatic score_t sat16(input wide_t v);
    if (v > wide_t'(32767)) begin
      return score_t'(16'sh7fff);
    end else if (v < -wide_t'(32768)) begin
      return score_t'(16'sh8000);
    end
    return v[15:0];
  endfunction

  function automatic score_t smax(input score_t a, input score_t b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

>>> design/gaas_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaas_cell: one Gotoh cell update
// H = max(diag + sub, E, F); new E and F from extend or open.
// ----------------------------------------------------------------------------
module gaas_cell (
  input  var gaas_pkg::score_t diag_i,
  input  var gaas_pkg::score_t e_i,
  input  var gaas_pkg::score_t f_i,
  input  var logic signed [7:0] sub_i,
  input  var logic [7:0]        gap_open_i,
  input  var logic [7:0]        gap_extend_i,
  output gaas_pkg::score_t      h_o,
  output gaas_pkg::score_t      e_o,
  output gaas_pkg::score_t      f_o
);
  import gaas_pkg::*;

  score_t h_sub;
  score_t h_best;
  score_t h_opn;

  always_comb begin
    h_sub  = sat16(wide_t'(diag_i) + wide_t'(sub_i));
    h_best = smax(smax(h_sub, e_i), f_i);
    h_opn  = sat16(wide_t'(h_best) - wide_t'({1'b0, gap_open_i}));
    h_o    = h_best;
    e_o    = smax(sat16(wide_t'(e_i) - wide_t'({1'b0, gap_extend_i})), h_opn);
    f_o    = smax(sat16(wide_t'(f_i) - wide_t'({1'b0, gap_extend_i})), h_opn);
  end

endmodule
`default_nettype wire

>>> design/global_affine_alignment_score.sv
`default_nettype none
// ----------------------------------------------------------------------------
// global_affine_alignment_score: affine-gap global alignment scorer
// Column-at-a-time Gotoh recurrence over a stored query, 16-bit saturating.
// ----------------------------------------------------------------------------
// Use:
//  - Command words enter on start_i while busy_o is low. Command 0 loads one
//    substitution table entry, command 1 one query residue; both are written
//    on acceptance and busy_o never rises. Command 3 is ignored.
//  - Command 2 carries one database residue. busy_o rises for the column:
//    a border pass over the L query cells (S_INIT) when first_column is set
//    (L = query length), border set-up in S_BR0 and S_BR1 through the shared
//    multiplier, then per query cell a query read (S_RD), a table read (S_TB)
//    and a cell update (S_EX), since each cell waits on two dependent
//    registered memory reads.
//  - After the column marked last_column, score_o carries the H of the last
//    query cell for one cycle with score_valid_o high; the receiver cannot
//    stall, so the word is simply presented once.
//  - gap_open, gap_extend and query_length sit behind the APB port at 0, 4, 8
//    and should only be written while busy_o is low.
//  - Reset clears the registers to 10, 1, 1 and the column counter; the table,
//    query and column memories hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module global_affine_alignment_score (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        psel,
  input  var logic        penable,
  input  var logic        pwrite,
  input  var logic [3:0]  paddr,
  input  var logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  var logic        start_i,
  output logic            busy_o,
  input  var logic [1:0]  command_i,
  input  var logic [4:0]  row_index_i,
  input  var logic [4:0]  column_index_i,
  input  var logic signed [7:0] table_value_i,
  input  var logic [9:0]  query_position_i,
  input  var logic [4:0]  residue_i,
  input  var logic        first_column_i,
  input  var logic        last_column_i,
  output gaas_pkg::score_t score_o,
  output logic            score_valid_o
);
  import gaas_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_BR0  = 3'd2;
  localparam logic [2:0] S_BR1  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_TB   = 3'd5;
  localparam logic [2:0] S_EX   = 3'd6;

  // configuration
  logic [7:0]      open_q, ext_q;
  logic [LenW-1:0] qlen_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 8'd10;
      ext_q  <= 8'd1;
      qlen_q <= LenW'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegOpen: open_q <= pwdata[7:0];
        RegExt:  ext_q  <= pwdata[7:0];
        RegLen:  qlen_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegOpen: prdata = {24'd0, open_q};
      RegExt:  prdata = {24'd0, ext_q};
      RegLen:  prdata = {{(32-LenW){1'b0}}, qlen_q};
      default: prdata = 32'd0;
    endcase
  end

  // active length: 0 taken as 1, clipped to the query store
  logic [LenW-1:0] len;
  always_comb begin
    if (qlen_q == '0) begin
      len = LenW'(1);
    end else if (qlen_q > LenW'(MaxQuery)) begin
      len = LenW'(MaxQuery);
    end else begin
      len = qlen_q;
    end
  end

  // sequencer
  logic [2:0]      state_q, state_d;
  logic [LenW-1:0] idx_q;
  logic [15:0]     dbpos_q;
  logic [4:0]      res_q;
  logic            last_q;
  score_t          diag_q, f_q;
  logic            accept;
  logic            idx_end;

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i & ~busy_o;
  assign idx_end = (idx_q == len - LenW'(1));

  // shared border unit: sat16(-open - ext*k)
  logic [15:0] bk;
  logic [23:0] bprod;
  score_t      border;
  always_comb begin
    case (state_q)
      S_BR0:   bk = dbpos_q;
      S_BR1:   bk = dbpos_q - 16'd1;
      default: bk = 16'(idx_q);
    endcase
    bprod  = 24'(ext_q) * 24'(bk);
    border = sat16(-wide_t'({1'b0, open_q}) - wide_t'({1'b0, bprod}));
  end

  score_t border_opn;
  assign border_opn = sat16(wide_t'(border) - wide_t'({1'b0, open_q}));

  // memories
  logic signed [7:0] tab_mem [0:TabDepth-1];
  logic [4:0]        qry_mem [0:MaxQuery-1];
  score_t            h_mem   [0:MaxQuery-1];
  score_t            e_mem   [0:MaxQuery-1];

  logic signed [7:0] tab_rd_q;
  logic [4:0]        qry_rd_q;
  score_t            h_rd_q, e_rd_q;
  logic              sub_ok_q;
  logic [TAW-1:0]    tab_addr;

  assign tab_addr = TAW'(res_q) * TAW'(AlphabetSize) + TAW'(qry_rd_q);

  always_ff @(posedge clk_i) begin
    if (accept && command_i == CmdTable &&
        row_index_i < 5'(AlphabetSize) && column_index_i < 5'(AlphabetSize)) begin
      tab_mem[TAW'(row_index_i) * TAW'(AlphabetSize) + TAW'(column_index_i)] <=
        table_value_i;
    end
    if (accept && command_i == CmdQuery) begin
      qry_mem[query_position_i] <= residue_i;
    end
    if (state_q == S_TB) begin
      tab_rd_q <= tab_mem[tab_addr];
      sub_ok_q <= (res_q < 5'(AlphabetSize)) && (qry_rd_q < 5'(AlphabetSize));
    end
    if (state_q == S_RD) begin
      qry_rd_q <= qry_mem[idx_q[QAW-1:0]];
      h_rd_q   <= h_mem[idx_q[QAW-1:0]];
      e_rd_q   <= e_mem[idx_q[QAW-1:0]];
    end
  end

  // cell update
  score_t cell_h, cell_e, cell_f;
  gaas_cell u_cell (
    .diag_i       (diag_q),
    .e_i          (e_rd_q),
    .f_i          (f_q),
    .sub_i        (sub_ok_q ? tab_rd_q : 8'sd0),
    .gap_open_i   (open_q),
    .gap_extend_i (ext_q),
    .h_o          (cell_h),
    .e_o          (cell_e),
    .f_o          (cell_f)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT) begin
      h_mem[idx_q[QAW-1:0]] <= border;
      e_mem[idx_q[QAW-1:0]] <= border_opn;
    end else if (state_q == S_EX) begin
      h_mem[idx_q[QAW-1:0]] <= cell_h;
      e_mem[idx_q[QAW-1:0]] <= cell_e;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && command_i == CmdDb) begin
        state_d = first_column_i ? S_INIT : S_BR0;
      end
      S_INIT: if (idx_end) state_d = S_BR0;
      S_BR0:  state_d = S_BR1;
      S_BR1:  state_d = S_RD;
      S_RD:   state_d = S_TB;
      S_TB:   state_d = S_EX;
      S_EX:   state_d = idx_end ? S_IDLE : S_RD;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      dbpos_q       <= '0;
      score_valid_o <= 1'b0;
    end else begin
      state_q       <= state_d;
      score_valid_o <= (state_q == S_EX) && idx_end && last_q;
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (accept && command_i == CmdDb && first_column_i) dbpos_q <= '0;
        end
        S_INIT: idx_q <= idx_end ? '0 : idx_q + LenW'(1);
        S_EX: begin
          idx_q <= idx_q + LenW'(1);
          if (idx_end && dbpos_q != 16'hffff) dbpos_q <= dbpos_q + 16'd1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= residue_i;
      last_q <= last_column_i;
    end
    case (state_q)
      S_BR0: f_q    <= border_opn;
      S_BR1: diag_q <= (dbpos_q == 16'd0) ? score_t'(0) : border;
      S_EX: begin
        f_q    <= cell_f;
        diag_q <= h_rd_q;
        if (idx_end) score_o <= cell_h;
      end
      default: ;
    endcase
  end

  // checks
  a_no_score_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    score_valid_o |-> !busy_o) else $error("score while busy");
  a_db_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CmdDb) |=> busy_o) else $error("column not started");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EX || state_q == S_INIT) |-> idx_q < len) else $error("index past length");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i != CmdDb) |=> !busy_o) else $error("load made block busy");

endmodule
`default_nettype wire

>>> bench/global_affine_alignment_score_test.sv
// ----------------------------------------------------------------------------
// global_affine_alignment_score_test: self-checking bench for the scorer
// Loads table and query words, runs columns of database residues under many
// gap and length settings, and checks each score word against a predictor.
// ----------------------------------------------------------------------------
module global_affine_alignment_score_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gaas_pkg::*;

  localparam int CycleLimit = 4_000_000;
  localparam int QueryFill  = 200;

  typedef struct {
    logic [1:0]        cmd;
    logic [4:0]        row;
    logic [4:0]        col;
    logic signed [7:0] tv;
    logic [9:0]        qpos;
    logic [4:0]        res;
    logic              first;
    logic              last;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = CmdNone;
  logic [4:0]  row_index_i = '0;
  logic [4:0]  column_index_i = '0;
  logic signed [7:0] table_value_i = '0;
  logic [9:0]  query_position_i = '0;
  logic [4:0]  residue_i = '0;
  logic        first_column_i = 1'b0;
  logic        last_column_i = 1'b0;
  score_t      score_o;
  logic        score_valid_o;

  global_affine_alignment_score u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_i, .busy_o, .command_i, .row_index_i, .column_index_i, .table_value_i,
    .query_position_i, .residue_i, .first_column_i, .last_column_i,
    .score_o, .score_valid_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: a mirror of the block's memories and registers
  logic signed [7:0] subst_mirror [AlphabetSize*AlphabetSize];
  logic [4:0]        query_mirror [MaxQuery];
  score_t            h_column [MaxQuery];
  score_t            e_column [MaxQuery];
  int                column_count;
  int                open_cost = 10;
  int                extend_cost = 1;
  int                length_reg = 1;

  score_t expected_scores [$];
  int     errors = 0;
  int     cycles = 0;
  bit     need_first = 1'b1; // a column must restart borders before any use
  bit     quiet = 1'b0;      // when set, words go back to back

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int used_length();
    if (length_reg == 0) return 1;
    if (length_reg > MaxQuery) return MaxQuery;
    return length_reg;
  endfunction

  function automatic int gap_border(input int k);
    return clamp16(-open_cost - extend_cost * k);
  endfunction

  // residue codes in use: the low codes, the top code and codes past the alphabet
  function automatic logic [4:0] pick_code();
    int r;
    r = $urandom_range(0, 16);
    if (r < 8) return 5'(r);
    if (r == 8) return 5'(AlphabetSize - 1);
    return 5'(AlphabetSize + r - 9);
  endfunction

  // mirrors table and query loads and runs the Gotoh column update; pushes the final H when the column is marked last
  function automatic void predict_word(input word_t w);
    int len, i, diag, f, up, e, h, ho, sub;
    case (w.cmd)
      CmdTable: begin
        if (w.row < AlphabetSize && w.col < AlphabetSize)
          subst_mirror[w.row*AlphabetSize + w.col] = w.tv;
      end
      CmdQuery: query_mirror[w.qpos] = w.res;
      CmdDb: begin
        len = used_length();
        if (w.first) begin
          column_count = 0;
          for (i = 0; i < len; i++) begin
            h_column[i] = score_t'(gap_border(i));
            e_column[i] = score_t'(clamp16(gap_border(i) - open_cost));
          end
        end
        diag = (column_count == 0) ? 0 : gap_border(column_count - 1);
        f = clamp16(gap_border(column_count) - open_cost);
        for (i = 0; i < len; i++) begin
          up = h_column[i];
          e = e_column[i];
          sub = (w.res < AlphabetSize && query_mirror[i] < AlphabetSize) ?
                int'(subst_mirror[w.res*AlphabetSize + query_mirror[i]]) : 0;
          h = clamp16(diag + sub);
          if (e > h) h = e;
          if (f > h) h = f;
          ho = clamp16(h - open_cost);
          e_column[i] = score_t'((clamp16(e - extend_cost) > ho) ?
                                 clamp16(e - extend_cost) : ho);
          f = (clamp16(f - extend_cost) > ho) ? clamp16(f - extend_cost) : ho;
          h_column[i] = score_t'(h);
          diag = up;
        end
        if (column_count < 65535) column_count++;
        if (w.last) expected_scores.push_back(h_column[len-1]);
      end
      default: ;
    endcase
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one command word; held until start_i meets busy_o low at a rising edge
  task automatic send_word(input word_t w);
    int gap;
    start_i          <= 1'b1;
    command_i        <= w.cmd;
    row_index_i      <= w.row;
    column_index_i   <= w.col;
    table_value_i    <= w.tv;
    query_position_i <= w.qpos;
    residue_i        <= w.res;
    first_column_i   <= w.first;
    last_column_i    <= w.last;
    do @(posedge clk_i); while (busy_o);
    predict_word(w);
    if (w.cmd == CmdDb) need_first = 1'b0;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic word_t noise_word();
    word_t w;
    w.cmd   = 2'($urandom);
    w.row   = 5'($urandom);
    w.col   = 5'($urandom);
    w.tv    = 8'($urandom);
    w.qpos  = 10'($urandom);
    w.res   = pick_code();
    w.first = 1'($urandom);
    w.last  = 1'($urandom);
    return w;
  endfunction

  task automatic send_table(input int r, input int c, input int v);
    word_t w;
    w = noise_word();
    w.cmd = CmdTable; w.row = 5'(r); w.col = 5'(c); w.tv = 8'(v);
    send_word(w);
  endtask

  task automatic send_query(input int p, input int r);
    word_t w;
    w = noise_word();
    w.cmd = CmdQuery; w.qpos = 10'(p); w.res = 5'(r);
    send_word(w);
  endtask

  task automatic send_column(input int r, input bit first, input bit last);
    word_t w;
    w = noise_word();
    w.cmd = CmdDb; w.res = 5'(r); w.first = first | need_first; w.last = last;
    send_word(w);
  endtask

  // idle: all scores in, then room for a column that emits nothing
  task automatic wait_idle();
    start_i <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk_i);
    repeat (4*used_length() + 8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    wait_idle();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegOpen: open_cost = value & 'hff;
      RegExt:  extend_cost = value & 'hff;
      default: length_reg = value & 'h7ff;
    endcase
    need_first = 1'b1;
    @(posedge clk_i);
  endtask

  task automatic set_gaps(input int o, input int e, input int len);
    write_reg(RegOpen, o);
    write_reg(RegExt, e);
    write_reg(RegLen, len);
  endtask

  // table entries for every code in use and the query cells any length reaches,
  // so no later read meets an unwritten entry
  task automatic test_load_all();
    int codes [9] = '{0, 1, 2, 3, 4, 5, 6, 7, 23};
    quiet = 1'b1;
    foreach (codes[r])
      foreach (codes[c])
        send_table(codes[r], codes[c], $urandom_range(0, 255) - 128);
    for (int p = 0; p < QueryFill; p++) send_query(p, pick_code());
    quiet = 1'b0;
    send_table(0, 0, -128);
    send_table(23, 23, 127);
    // codes outside the alphabet must leave the table alone
    send_table(31, 0, 55);
    send_table(0, 24, -55);
    send_table(24, 31, 1);
  endtask

  task automatic test_directed();
    word_t w;
    // reset values of the gap registers, one-cell query
    send_column(0, 1'b1, 1'b1);
    send_column(23, 1'b1, 1'b1);
    send_column(31, 1'b0, 1'b1);
    w = noise_word(); w.cmd = CmdNone; send_word(w);
    set_gaps(0, 0, 8);
    send_column(5, 1'b1, 1'b0);
    send_column(24, 1'b0, 1'b1);
    set_gaps(255, 255, 8);
    send_column(0, 1'b1, 1'b0);
    send_column(6, 1'b0, 1'b1);
    send_column(23, 1'b0, 1'b1);
    // a column with no score, then a config write must still wait for it
    send_column(3, 1'b1, 1'b0);
  endtask

  // deep negative borders over a long query, then free gaps with a strong match
  task automatic test_saturation();
    set_gaps(255, 255, QueryFill);
    for (int k = 0; k < 6; k++) send_column(pick_code(), k == 0, k == 2 || k == 5);
    set_gaps(0, 0, QueryFill);
    send_table(5, 5, 127);
    for (int k = 0; k < 4; k++) send_column(5, k == 0, k == 3);
  endtask

  // lengths 0, 1 and QueryFill; 0 is taken as one cell
  task automatic test_length_limits();
    int lens [3] = '{0, 1, QueryFill};
    foreach (lens[n]) begin
      set_gaps($urandom_range(0, 255), $urandom_range(0, 255), lens[n]);
      send_column(pick_code(), 1'b1, 1'b0);
      send_column(pick_code(), 1'b0, 1'b1);
    end
  endtask

  task automatic test_random();
    int sent = 0;
    int len, r, cols;
    while (sent < 200) begin
      r = $urandom_range(0, 9);
      len = (r < 8) ? $urandom_range(1, 16) : $urandom_range(17, 96);
      set_gaps($urandom_range(0, 255), $urandom_range(0, 255), len);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        cols = $urandom_range(1, 12);
        for (int k = 0; k < cols; k++) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            send_table($urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 255) - 128);
          end else if (r < 16) begin
            send_query($urandom_range(0, 1023), pick_code());
          end else if (r < 20) begin
            send_word(noise_word() ) ;
          end
          send_column(pick_code(), k == 0 && $urandom_range(0, 3) != 0,
                      k == cols - 1 || $urandom_range(0, 5) == 0);
          sent += (r < 20) ? 2 : 1;
        end
      end
    end
    quiet = 1'b0;
  endtask

  // scores are only present for one cycle; sampled at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && score_valid_o) begin
      if (expected_scores.size() == 0) begin
        $display("%0t: unexpected score word, expected none, actual %0d", $time, score_o);
        errors++;
      end else begin
        if (score_o !== expected_scores[0]) begin
          $display("%0t: score mismatch, expected %0d, actual %0d",
                   $time, expected_scores[0], score_o);
          errors++;
        end
        void'(expected_scores.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("global_affine_alignment_score test failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_all();
    test_directed();
    test_saturation();
    test_length_limits();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("global_affine_alignment_score test passed");
    end else begin
      $display("global_affine_alignment_score test failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/gaas_pkg.sv
design/gaas_cell.sv
design/global_affine_alignment_score.sv
bench/global_affine_alignment_score_test.sv
